// ===== hw/rtl/bvm_pkg.sv =====
// ----------------------------------------------------------------------------
// bvm_pkg
// shared types and constants of the byte-coded register machine execute unit
// ----------------------------------------------------------------------------
package bvm_pkg;

  localparam logic [7:0] OP_ADD    = 8'h01;
  localparam logic [7:0] OP_SUB    = 8'h02;
  localparam logic [7:0] OP_MUL    = 8'h03;
  localparam logic [7:0] OP_MULCP  = 8'h04;
  localparam logic [7:0] OP_DIVCP  = 8'h05;
  localparam logic [7:0] OP_ADD2   = 8'h06;
  localparam logic [7:0] OP_LDI16  = 8'h07;
  localparam logic [7:0] OP_LDI32  = 8'h08;
  localparam logic [7:0] OP_SYSCALL = 8'h20;
  localparam logic [7:0] OP_HALT   = 8'h7F;

  localparam int PTR_REG      = 8'h12;
  localparam int SYS_CODE_REG = 8'h07;
  localparam int SYS_ARG_REG  = 8'h08;
  localparam int SYS_CHAR_REG = 8'h09;

  localparam logic [16:0] MEM_RESET = 17'd4096;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_SYS = 3'd1;
  localparam logic [2:0] ST_MEM_END = 3'd2;
  localparam logic [2:0] ST_BAD_REG = 3'd3;
  localparam logic [2:0] ST_DIV0    = 3'd4;

  // datapath register-read selects
  typedef enum logic [2:0] {
    RS_PTR, RS_A, RS_B, RS_CODE, RS_ARG, RS_CHAR
  } rsel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_PTR, S_CHK, S_RD_A, S_RD_B, S_EXEC, S_DIV, S_WR_A, S_WR_C,
    S_SYS_ARG, S_SYS_CHAR, S_SYS_DONE, S_WR_PTR, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  load_in;     // capture the instruction
    logic  rd_en;
    rsel_t rd_sel;
    logic  cap_ptr;
    logic  cap_a;
    logic  cap_b;
    logic  cap_code;
    logic  cap_arg;
    logic  cap_char;
    logic  calc;        // compute result of add/sub/mul/load
    logic  div_start;
    logic  wr_a;
    logic  wr_c;
    logic  wr_ptr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mem_end;
    logic idx_bad;
    logic div_zero;
    logic div_done;
    logic code_zero;
    logic code_one;
  } stat_t;

endpackage

// ===== hw/rtl/bvm_div.sv =====
// ----------------------------------------------------------------------------
// bvm_div
// signed 32-bit truncating divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bvm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] rem_r, rem_nxt, q_r, q_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[31]} - {1'b0, d_r};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num[31] ? (32'd0 - num) : num;
      d_nxt    = den[31] ? (32'd0 - den) : den;
      neg_nxt  = num[31] ^ den[31];
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[31]};
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? (32'd0 - q_r) : q_r;
endmodule

// ===== hw/rtl/bvm_datapath.sv =====
// ----------------------------------------------------------------------------
// bvm_datapath
// register file, operand registers, alu and divider of the execute unit
// ----------------------------------------------------------------------------
module bvm_datapath #(
  parameter int REG_COUNT = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bvm_pkg::cmd_t      cmd,
  output bvm_pkg::stat_t     stat,
  input  logic [7:0]         in_op,
  input  logic signed [7:0]  in_b1,
  input  logic signed [7:0]  in_b2,
  input  logic signed [7:0]  in_b3,
  input  logic signed [7:0]  in_b4,
  input  logic signed [7:0]  in_b5,
  input  logic [16:0]        mem_limit,
  input  logic [2:0]         adv,
  output logic [31:0]        ptr,
  output logic [7:0]         op,
  output logic [31:0]        arg,
  output logic [7:0]         chr
);
  import bvm_pkg::*;
  localparam int IW = $clog2(REG_COUNT);

  logic [31:0] rf [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic        rvld_r;
  logic [31:0] rdata;
  logic [7:0]  op_r, b1_r, b2_r, b3_r, b4_r, b5_r;
  logic [31:0] rdata_r, ptr_r, va_r, vb_r, code_r, arg_r, res_r;
  logic [7:0]  chr_r;
  logic [IW-1:0] rd_idx, wr_idx;
  logic          wr_en;
  logic [31:0]   wr_data;
  logic [31:0]   prod;
  logic          dv_done;
  logic [31:0]   dv_q;
  logic          ok_a, ok_b, ok_c, bad;

  function automatic logic idx_ok(input logic [7:0] i);
    return !i[7] && ({24'd0, i} < 32'(REG_COUNT));
  endfunction

  assign ok_a = idx_ok(b1_r);
  assign ok_b = idx_ok(b2_r);
  assign ok_c = idx_ok(b3_r);

  always_comb begin
    case (op_r)
      OP_ADD, OP_SUB, OP_MUL, OP_ADD2: bad = !ok_a || !ok_b;
      OP_MULCP, OP_DIVCP:               bad = !ok_a || !ok_b || !ok_c;
      OP_LDI16, OP_LDI32:               bad = !ok_a;
      default:                          bad = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RS_PTR:  rd_idx = IW'(PTR_REG);
      RS_A:    rd_idx = b1_r[IW-1:0];
      RS_B:    rd_idx = b2_r[IW-1:0];
      RS_CODE: rd_idx = IW'(SYS_CODE_REG);
      RS_ARG:  rd_idx = IW'(SYS_ARG_REG);
      RS_CHAR: rd_idx = IW'(SYS_CHAR_REG);
      default: rd_idx = IW'(PTR_REG);
    endcase
  end

  assign prod = va_r * vb_r;

  always_comb begin
    wr_en   = cmd.wr_a || cmd.wr_c || cmd.wr_ptr;
    wr_idx  = b1_r[IW-1:0];
    wr_data = res_r;
    if (cmd.wr_c) wr_idx = b3_r[IW-1:0];
    if (cmd.wr_ptr) begin
      wr_idx  = IW'(PTR_REG);
      wr_data = ptr_r + {29'd0, adv};
    end
  end

  // register file: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) rf[wr_idx] <= wr_data;
    if (cmd.rd_en) rdata_r <= rf[rd_idx];
  end

  // written flags: an entry not written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_idx] <= 1'b1;
      if (cmd.rd_en) rvld_r <= vld_r[rd_idx];
    end
  end

  assign rdata = rvld_r ? rdata_r : 32'd0;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= in_op;
      b1_r <= in_b1;
      b2_r <= in_b2;
      b3_r <= in_b3;
      b4_r <= in_b4;
      b5_r <= in_b5;
    end
    if (cmd.cap_ptr)  ptr_r  <= rdata;
    if (cmd.cap_a)    va_r   <= rdata;
    if (cmd.cap_b)    vb_r   <= rdata;
    if (cmd.cap_code) code_r <= rdata;
    if (cmd.cap_arg)  arg_r  <= rdata;
    if (cmd.cap_char) chr_r  <= rdata[7:0];
    // advanced pointer kept alongside the register file copy
    if (cmd.wr_ptr) ptr_r <= wr_data;
    if (cmd.calc) begin
      case (op_r)
        OP_SUB:            res_r <= va_r - vb_r;
        OP_MUL, OP_MULCP:  res_r <= prod;
        OP_LDI16:          res_r <= {{16{b2_r[7]}}, b2_r, 8'd0} + {{24{b3_r[7]}}, b3_r};
        OP_LDI32:          res_r <= {b2_r, 24'd0} + {{8{b3_r[7]}}, b3_r, 16'd0}
                                  + {{16{b4_r[7]}}, b4_r, 8'd0} + {{24{b5_r[7]}}, b5_r};
        default:           res_r <= va_r + vb_r;
      endcase
    end
    if (dv_done) res_r <= dv_q;
    // pointer write picks up a register write into the pointer itself
    if (cmd.wr_a && !cmd.wr_ptr && b1_r[IW-1:0] == IW'(PTR_REG)) ptr_r <= res_r;
    if (cmd.wr_c && b3_r[IW-1:0] == IW'(PTR_REG)) ptr_r <= res_r;
  end

  bvm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (va_r),
    .den   (vb_r),
    .done  (dv_done),
    .quo   (dv_q)
  );

  assign stat.mem_end   = ptr_r[31] || (ptr_r >= {15'd0, mem_limit});
  assign stat.idx_bad   = bad;
  assign stat.div_zero  = (vb_r == 32'd0);
  assign stat.div_done  = dv_done;
  assign stat.code_zero = (code_r == 32'd0);
  assign stat.code_one  = (code_r == 32'd1);

  assign ptr = ptr_r;
  assign op  = op_r;
  assign arg = arg_r;
  assign chr = chr_r;
endmodule

// ===== hw/rtl/bvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bvm_ctrl
// sequencer of the execute unit: reads, checks, executes, writes, reports
// ----------------------------------------------------------------------------
module bvm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  output bvm_pkg::cmd_t      cmd,
  input  bvm_pkg::stat_t     stat,
  input  logic [7:0]         op,
  input  logic [31:0]        arg,
  output logic [2:0]         adv,
  output logic               ch_valid,
  output logic               ch_stream,
  output logic               halted,
  output logic [31:0]        exit_code,
  output logic [2:0]         status
);
  import bvm_pkg::*;

  state_t      state_r, state_nxt;
  logic        stop_r, stop_nxt, chv_r, chv_nxt, chs_r, chs_nxt, ov_r, ov_nxt;
  logic [31:0] hcode_r, hcode_nxt;
  logic [2:0]  hst_r, hst_nxt, st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stop_r  <= 1'b0;
      hcode_r <= '0;
      hst_r   <= ST_OK;
      st_r    <= ST_OK;
      chv_r   <= 1'b0;
      chs_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stop_r  <= stop_nxt;
      hcode_r <= hcode_nxt;
      hst_r   <= hst_nxt;
      st_r    <= st_nxt;
      chv_r   <= chv_nxt;
      chs_r   <= chs_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_ADD2: adv = 3'd3;
      OP_MULCP, OP_DIVCP, OP_LDI16:    adv = 3'd4;
      OP_LDI32:                        adv = 3'd6;
      default:                         adv = 3'd1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    stop_nxt  = stop_r;
    hcode_nxt = hcode_r;
    hst_nxt   = hst_r;
    st_nxt    = st_r;
    chv_nxt   = chv_r;
    chs_nxt   = chs_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    cmd.rd_sel = RS_PTR;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          st_nxt  = ST_OK;
          chv_nxt = 1'b0;
          chs_nxt = 1'b0;
          cmd.rd_en = 1'b1;
          state_nxt = stop_r ? S_WR_PTR : S_RD_PTR;
          if (stop_r) state_nxt = S_OUT;
          if (stop_r) ov_nxt = 1'b1;
        end
      end
      S_RD_PTR: begin
        cmd.cap_ptr = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RS_A;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.cap_a = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = (op == OP_SYSCALL) ? RS_CODE : RS_B;
        if (stat.mem_end) begin
          stop_nxt = 1'b1; hcode_nxt = 32'd4; hst_nxt = ST_MEM_END;
          ov_nxt = 1'b1; state_nxt = S_OUT;
        end else if (op == OP_HALT) begin
          stop_nxt = 1'b1; hcode_nxt = '0; hst_nxt = ST_OK;
          ov_nxt = 1'b1; state_nxt = S_OUT;
        end else if (stat.idx_bad) begin
          st_nxt = ST_BAD_REG; state_nxt = S_WR_PTR;
        end else if (op == OP_SYSCALL || adv != 3'd1) begin
          state_nxt = S_RD_B;
        end else begin
          state_nxt = S_WR_PTR;
        end
      end
      S_RD_B: begin
        if (op == OP_SYSCALL) begin
          cmd.cap_code = 1'b1;
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RS_ARG;
          state_nxt = S_SYS_ARG;
        end else begin
          cmd.cap_b = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op == OP_DIVCP) begin
          if (stat.div_zero) begin
            st_nxt = ST_DIV0; state_nxt = S_WR_PTR;
          end else begin
            cmd.div_start = 1'b1; state_nxt = S_DIV;
          end
        end else begin
          cmd.calc = 1'b1; state_nxt = S_WR_A;
        end
      end
      S_DIV: if (stat.div_done) state_nxt = S_WR_A;
      S_WR_A: begin
        cmd.wr_a = 1'b1;
        state_nxt = (op == OP_MULCP || op == OP_DIVCP) ? S_WR_C : S_WR_PTR;
      end
      S_WR_C: begin
        cmd.wr_c = 1'b1;
        state_nxt = S_WR_PTR;
      end
      S_SYS_ARG: begin
        cmd.cap_arg = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RS_CHAR;
        state_nxt = S_SYS_CHAR;
      end
      S_SYS_CHAR: begin
        cmd.cap_char = 1'b1;
        state_nxt = S_SYS_DONE;
      end
      S_SYS_DONE: begin
        if (stat.code_zero) begin
          stop_nxt = 1'b1; hcode_nxt = arg; hst_nxt = ST_OK;
          ov_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          if (stat.code_one) begin
            if (arg == 32'd1 || arg == 32'd2) begin
              chv_nxt = 1'b1;
              chs_nxt = (arg == 32'd2);
            end
          end else begin
            st_nxt = ST_BAD_SYS;
          end
          state_nxt = S_WR_PTR;
        end
      end
      S_WR_PTR: begin
        cmd.wr_ptr = 1'b1;
        cmd.cap_ptr = 1'b0;
        ov_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign cfg_ready = (state_r == S_IDLE);
  assign ch_valid  = chv_r;
  assign ch_stream = chs_r;
  assign halted    = stop_r;
  assign exit_code = stop_r ? hcode_r : 32'd0;
  assign status    = stop_r ? hst_r : st_r;

  // a result is only offered while waiting in the report state
  assert property (@(posedge clk) disable iff (!rst_n) ov_r |-> state_r == S_OUT)
    else $error("result valid outside report state");
  // once stopped the machine stays stopped
  assert property (@(posedge clk) disable iff (!rst_n) $past(stop_r) |-> stop_r)
    else $error("stopped flag fell");
  // no character alongside a halt
  assert property (@(posedge clk) disable iff (!rst_n) ov_r && stop_r |-> !chv_r)
    else $error("character emitted while halted");
  // configuration only in idle
  assert property (@(posedge clk) disable iff (!rst_n) cfg_valid && cfg_ready |-> in_stall == 1'b0)
    else $error("configuration outside idle");
endmodule

// ===== hw/rtl/bytecode_register_vm_execute.sv =====
// ----------------------------------------------------------------------------
// bytecode_register_vm_execute
// execute unit of a small byte-coded register machine
// ----------------------------------------------------------------------------
// One instruction beat in, one result beat out. Each instruction walks a
// sequencer around a register file (one write and one registered read per
// cycle): pointer and operand reads, execute, target write, pointer write,
// report. A multiply-with-copy also writes the copy, a divide first waits on
// the one-bit-per-cycle divider, and a system call reads code, argument and
// character. A divide by zero, bad index or unknown opcode skip to the pointer
// write; a halt, memory end or any step once halted skip to the report. A new
// instruction is taken only once the result beat is accepted. The register
// file and the pointer are held here; fetch is done by the caller using
// next_pointer. A written flag per register makes entries not written since
// reset read as zero, so the file itself needs no clearing.
// ----------------------------------------------------------------------------
module bytecode_register_vm_execute #(
  parameter int REG_COUNT = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_operation,
  input  logic signed [7:0] in_byte_one,
  input  logic signed [7:0] in_byte_two,
  input  logic signed [7:0] in_byte_three,
  input  logic signed [7:0] in_byte_four,
  input  logic signed [7:0] in_byte_five,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] out_next_pointer,
  output logic              out_char_valid,
  output logic              out_char_stream,
  output logic [7:0]        out_char_value,
  output logic              out_halted,
  output logic signed [31:0] out_exit_code,
  output logic [2:0]        out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [16:0]       cfg_mem_limit
);
  import bvm_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [16:0] lim_r;
  logic [2:0]  adv;
  logic [31:0] ptr, arg;
  logic [7:0]  op, chr;
  logic        chv;

  // memory limit register
  always_ff @(posedge clk) begin
    if (!rst_n) lim_r <= MEM_RESET;
    else if (cfg_valid && cfg_ready) lim_r <= cfg_mem_limit;
  end

  bvm_datapath #(.REG_COUNT(REG_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (in_operation),
    .in_b1     (in_byte_one),
    .in_b2     (in_byte_two),
    .in_b3     (in_byte_three),
    .in_b4     (in_byte_four),
    .in_b5     (in_byte_five),
    .mem_limit (lim_r),
    .adv       (adv),
    .ptr       (ptr),
    .op        (op),
    .arg       (arg),
    .chr       (chr)
  );

  bvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .stat      (stat),
    .op        (op),
    .arg       (arg),
    .adv       (adv),
    .ch_valid  (chv),
    .ch_stream (out_char_stream),
    .halted    (out_halted),
    .exit_code (out_exit_code),
    .status    (out_status)
  );

  assign out_next_pointer = ptr;
  assign out_char_valid   = chv;
  assign out_char_value   = chv ? chr : 8'd0;
endmodule
